FILE: rtl/utf8_codepoint_decoder_unit_defines.svh
// Assertion macros used by the UTF-8 decoder datapath.
`ifndef UTF8_CODEPOINT_DECODER_UNIT_DEFINES_SVH
`define UTF8_CODEPOINT_DECODER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define U8DEC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define U8DEC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/u8dec_pkg.sv
// Types, constants and decode helpers for the UTF-8 decoder.
package u8dec_pkg;

  localparam int QDEPTH = 4;

  localparam logic [20:0] REPL_CP  = 21'h00FFFD;
  localparam logic [20:0] CP_MIN2  = 21'h000080;
  localparam logic [20:0] CP_MIN3  = 21'h000800;
  localparam logic [20:0] CP_MIN4  = 21'h010000;
  localparam logic [20:0] CP_MAX   = 21'h10FFFF;

  // Sequence length codes from a start byte
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef logic [QDEPTH-1:0][7:0] byte_queue_t;

  typedef struct packed {
    logic emit;   // load one result into the output register and consume bytes
    logic take;   // append the accepted input byte to the queue
  } ctrl_cmd_t;

  typedef struct packed {
    logic hold_now;   // queue holds an unfinished sequence, nothing to emit
    logic emit_last;  // the result on offer is the final one for this byte
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

  typedef struct packed {
    logic        repl;
    logic [20:0] cp;
  } decode_t;

  function automatic logic is_cont(logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] len;
    if (!b[7])                len = LEN_ONE;
    else if (b <= 8'hBF)      len = LEN_NONE;
    else if (b <= 8'hDF)      len = LEN_TWO;
    else if (b <= 8'hEF)      len = LEN_THREE;
    else if (b <= 8'hF7)      len = LEN_FOUR;
    else                      len = LEN_NONE;
    return len;
  endfunction

  // Lead plus the run of continuation bytes that follow it, capped by len and cnt.
  function automatic logic [2:0] count_cont(byte_queue_t q, logic [2:0] len,
                                            logic [2:0] cnt);
    logic [2:0] k;
    logic       run;
    k   = 3'd1;
    run = 1'b1;
    for (int j = 1; j < QDEPTH; j++) begin
      if (run && (3'(j) < len) && (3'(j) < cnt) && is_cont(q[j])) begin
        k = 3'(j + 1);
      end else begin
        run = 1'b0;
      end
    end
    return k;
  endfunction

  // True when the queue is a valid but unfinished sequence and the stream goes on.
  function automatic logic hold_check(byte_queue_t q, logic [2:0] cnt, logic fl);
    logic [2:0] len;
    logic [2:0] k;
    len = lead_len(q[0]);
    k   = count_cont(q, len, cnt);
    return (cnt != 3'd0) && (len >= LEN_TWO) && (k == cnt) && (cnt < len) && !fl;
  endfunction

  function automatic decode_t decode_seq(byte_queue_t q, logic [2:0] len);
    decode_t    d;
    logic [20:0] val;
    logic        ok;
    case (len)
      LEN_TWO: begin
        val = {10'd0, q[0][4:0], q[1][5:0]};
        ok  = val >= CP_MIN2;
      end
      LEN_THREE: begin
        val = {5'd0, q[0][3:0], q[1][5:0], q[2][5:0]};
        ok  = val >= CP_MIN3;
      end
      default: begin
        val = {q[0][2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
        ok  = (val >= CP_MIN4) && (val <= CP_MAX);
      end
    endcase
    d.repl = !ok;
    d.cp   = ok ? val : REPL_CP;
    return d;
  endfunction

endpackage

FILE: rtl/u8dec_byte_if.sv
// Input channel: one raw byte per transaction with an end-of-stream flag.
interface u8dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       flush;

  modport source (output valid, output data_byte, output flush, input ready);
  modport sink   (input valid, input data_byte, input flush, output ready);
endinterface

FILE: rtl/u8dec_cp_if.sv
// Output channel: one decoded code point per transaction.
interface u8dec_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        is_replacement;
  logic        last;

  modport source (output valid, output code_point, output is_replacement, output last,
                  input ready);
  modport sink   (input valid, input code_point, input is_replacement, input last,
                  output ready);
endinterface

FILE: rtl/u8dec_ctrl.sv
// Controller state machine: sequences byte intake and result emission.
module u8dec_ctrl
  import u8dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       in_ready
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.emit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RUN: begin
        cmd.emit = !status.hold_now && status.out_free;
        in_ready = status.hold_now || (status.out_free && status.emit_last);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.take = in_valid && in_ready;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.take) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.hold_now || (status.out_free && status.emit_last)) begin
          state_next = cmd.take ? ST_RUN : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/u8dec_datapath.sv
// Datapath: byte queue, sequence decode, and output register.
`include "utf8_codepoint_decoder_unit_defines.svh"

module u8dec_datapath
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic [7:0]  data_byte,
  input  logic        flush,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_cp,
  output logic        out_repl,
  output logic        out_last
);

  byte_queue_t q;
  logic [2:0]  cnt;
  logic        flush_r;

  logic [2:0]  len;
  logic [2:0]  k;
  decode_t     dec;
  logic [20:0] step_cp;
  logic        step_repl;
  logic [2:0]  adv;
  byte_queue_t sq;
  logic [2:0]  cnt_after;
  logic [2:0]  idx [QDEPTH];
  byte_queue_t base_q;
  logic [2:0]  base_cnt;
  byte_queue_t take_q;

  // Evaluate the sequence at the head of the queue
  always_comb begin
    len = lead_len(q[0]);
    k   = count_cont(q, len, cnt);
    dec = decode_seq(q, len);
    if (len == LEN_ONE) begin
      step_cp   = {13'd0, q[0]};
      step_repl = 1'b0;
      adv       = 3'd1;
    end else if (len == LEN_NONE) begin
      step_cp   = REPL_CP;
      step_repl = 1'b1;
      adv       = 3'd1;
    end else if (k == len) begin
      step_cp   = dec.cp;
      step_repl = dec.repl;
      adv       = len;
    end else begin
      // Broken or flushed sequence: the lead alone is replaced
      step_cp   = REPL_CP;
      step_repl = 1'b1;
      adv       = 3'd1;
    end
  end

  // Queue after consuming the head
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      idx[i] = 3'(i) + adv;
      sq[i]  = (idx[i] < 3'(QDEPTH)) ? q[idx[i][1:0]] : q[i];
    end
    cnt_after = cnt - adv;
  end

  assign status.hold_now  = hold_check(q, cnt, flush_r);
  assign status.emit_last = (cnt_after == 3'd0) || hold_check(sq, cnt_after, flush_r);
  assign status.out_free  = !out_valid || out_ready;

  assign base_q   = cmd.emit ? sq : q;
  assign base_cnt = cmd.emit ? cnt_after : cnt;

  // Append the accepted byte behind whatever stays queued
  always_comb begin
    take_q                = base_q;
    take_q[base_cnt[1:0]] = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (cmd.take) begin
      cnt <= base_cnt + 3'd1;
    end else if (cmd.emit) begin
      cnt <= cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      q       <= take_q;
      flush_r <= flush;
    end else if (cmd.emit) begin
      q <= sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cp   <= step_cp;
      out_repl <= step_repl;
      out_last <= status.emit_last;
    end
  end

  `U8DEC_ASSERT_IMP(a_repl_value, clk, rst, out_valid && out_repl,
                    out_cp == REPL_CP, "replacement result without U+FFFD")
  `U8DEC_ASSERT_IMP(a_cp_range, clk, rst, out_valid, out_cp <= CP_MAX,
                    "code point above U+10FFFF")
  `U8DEC_ASSERT_NXT(a_take_fills, clk, rst, cmd.take,
                    (cnt != 3'd0) && (cnt <= 3'(QDEPTH)),
                    "byte queue count wrong after intake")
  `U8DEC_ASSERT_NXT(a_last_drains, clk, rst, cmd.emit && status.emit_last && !cmd.take,
                    (cnt == 3'd0) || hold_check(q, cnt, flush_r),
                    "queue not drained or held after last result")

endmodule

FILE: rtl/utf8_codepoint_decoder_unit.sv
// Top level of the UTF-8 to code point decoder.
//
//   channel   dir  payload                               handshake
//   byte_in   in   data_byte[7:0], flush                 valid/ready
//   cp_out    out  code_point[20:0], is_replacement, last valid/ready
//
// Plain ASCII, where each byte completes or breaks nothing beyond itself,
// streams at one byte per clock while cp_out accepts. A byte that ends a
// sequence gives one result per cycle while cp_out accepts, up to four when
// held bytes are replayed after a broken sequence or a flush; input waits
// during replay. A byte that only extends a held sequence gives no result.
// Reset (rst, synchronous) empties the byte queue and the output register.
// A stalled cp_out holds the decode loop; the next byte is still accepted
// while the final result of the previous one waits in the output register.
module utf8_codepoint_decoder_unit
  import u8dec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  u8dec_byte_if.sink    byte_in,
  u8dec_cp_if.source    cp_out
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  // Controller: decides when to take a byte and when to emit a result
  u8dec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  assign byte_in.ready = in_ready;

  // Datapath: holds the pending bytes, decodes the head, drives the output
  u8dec_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .data_byte (byte_in.data_byte),
    .flush     (byte_in.flush),
    .out_valid (cp_out.valid),
    .out_ready (cp_out.ready),
    .out_cp    (cp_out.code_point),
    .out_repl  (cp_out.is_replacement),
    .out_last  (cp_out.last)
  );

endmodule

FILE: dv/utf8_codepoint_decoder_unit_checker.sv
// Scoreboard for the UTF-8 decoder: predicts code points from accepted bytes and checks results.
`timescale 1ns / 100ps
module utf8_codepoint_decoder_unit_checker
  import u8dec_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  u8dec_byte_if byte_mon,
  u8dec_cp_if   cp_mon,
  output int    mismatch_count,
  output int    cp_outstanding
);

  localparam logic [1:0] CONT_TAG    = 2'b10;
  localparam int         MAX_PRINTED = 40;

  typedef struct packed {
    logic [20:0] cp;
    logic        repl;
    logic        last;
  } cp_result_t;

  cp_result_t cp_expected [$];
  logic [7:0] held_byte [3];
  int         held_count;

  initial begin
    mismatch_count = 0;
    cp_outstanding = 0;
    held_count     = 0;
  end

  function automatic logic [2:0] start_len(logic [7:0] b);
    casez (b)
      8'b0???????: return LEN_ONE;
      8'b110?????: return LEN_TWO;
      8'b1110????: return LEN_THREE;
      8'b11110???: return LEN_FOUR;
      default:     return LEN_NONE;
    endcase
  endfunction

  // Run held bytes plus the new one through the decoder; queue what comes out.
  function automatic void predict_byte(logic [7:0] din, logic fl);
    logic [7:0]  q [4];
    cp_result_t  step_out [$];
    cp_result_t  r;
    logic [2:0]  len;
    logic [20:0] val;
    logic        ok;
    logic        holding;
    int          n;
    int          pos;
    int          k;
    int          avail;
    int          i;
    n       = 0;
    pos     = 0;
    holding = 1'b0;
    for (i = 0; i < held_count; i++) begin
      q[n] = held_byte[i];
      n++;
    end
    q[n] = din;
    n++;
    while (pos < n && !holding) begin
      len   = start_len(q[pos]);
      avail = n - pos;
      r     = '0;
      if (len == LEN_ONE) begin
        r.cp = {13'd0, q[pos]};
        step_out.push_back(r);
        pos++;
      end else if (len == LEN_NONE) begin
        r.cp   = REPL_CP;
        r.repl = 1'b1;
        step_out.push_back(r);
        pos++;
      end else begin
        k = 1;
        while (k < len && k < avail && q[pos + k][7:6] == CONT_TAG) k++;
        if (k == len) begin
          case (len)
            LEN_TWO: begin
              val = {10'd0, q[pos][4:0], q[pos + 1][5:0]};
              ok  = val >= CP_MIN2;
            end
            LEN_THREE: begin
              val = {5'd0, q[pos][3:0], q[pos + 1][5:0], q[pos + 2][5:0]};
              ok  = val >= CP_MIN3;
            end
            default: begin
              val = {q[pos][2:0], q[pos + 1][5:0], q[pos + 2][5:0], q[pos + 3][5:0]};
              ok  = val >= CP_MIN4 && val <= CP_MAX;
            end
          endcase
          r.cp   = ok ? val : REPL_CP;
          r.repl = !ok;
          step_out.push_back(r);
          pos += len;
        end else if (k < avail || fl) begin
          // broken or flushed: the lead alone is bad, replay what follows it
          r.cp   = REPL_CP;
          r.repl = 1'b1;
          step_out.push_back(r);
          pos++;
        end else begin
          for (i = 0; i < avail; i++) held_byte[i] = q[pos + i];
          held_count = avail;
          holding    = 1'b1;
        end
      end
    end
    if (!holding) held_count = 0;
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[j]) cp_expected.push_back(step_out[j]);
  endfunction

  task automatic report_mismatch(input string what, input logic [20:0] got,
                                 input logic [20:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cp_result_t want;
    if (rst) begin
      held_count = 0;
      cp_expected.delete();
    end else begin
      if (byte_mon.valid && byte_mon.ready)
        predict_byte(byte_mon.data_byte, byte_mon.flush);
      if (cp_mon.valid && cp_mon.ready) begin
        if (cp_expected.size() == 0) begin
          report_mismatch("result with nothing expected", cp_mon.code_point, '0);
        end else begin
          want = cp_expected.pop_front();
          if (cp_mon.code_point !== want.cp)
            report_mismatch("code_point", cp_mon.code_point, want.cp);
          if (cp_mon.is_replacement !== want.repl)
            report_mismatch("is_replacement", {20'd0, cp_mon.is_replacement},
                            {20'd0, want.repl});
          if (cp_mon.last !== want.last)
            report_mismatch("last", {20'd0, cp_mon.last}, {20'd0, want.last});
        end
      end
    end
    cp_outstanding = cp_expected.size();
  end

endmodule

FILE: dv/utf8_codepoint_decoder_unit_test.sv
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus, result drain and verdict.
`timescale 1ns / 100ps
module utf8_codepoint_decoder_unit_test;
  import u8dec_pkg::*;

  localparam int BYTE_TARGET     = 350;   // random bytes after the directed part
  localparam int PHASE_BYTES     = 60;    // bytes between changes of the idle pattern
  localparam int HOLD_OFF_PHASE  = 3;     // phase in which the receiver backs off
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int IDLE_LIMIT      = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES    = 12;
  localparam int N_DIRECTED      = 26;

  // Directed bytes, {flush, data_byte}:
  //   top of ASCII; overlong two-byte NUL; a properly encoded U+FFFD (no error);
  //   first surrogate, which passes; U+10FFFF; an F5 lead, out of range;
  //   stray continuation; invalid byte FF; E2 82 broken by 'A', which replays
  //   the continuation; three held bytes resolved by flush; NUL with flush and
  //   nothing held.
  localparam logic [8:0] DIRECTED_BYTES [N_DIRECTED] = '{
    9'h07F,
    9'h0C0, 9'h080,
    9'h0EF, 9'h0BF, 9'h0BD,
    9'h0ED, 9'h0A0, 9'h080,
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
    9'h0F5, 9'h080, 9'h080, 9'h080,
    9'h0BF,
    9'h0FF,
    9'h0E2, 9'h082, 9'h041,
    9'h0F0, 9'h090, 9'h180,
    9'h100
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8dec_byte_if byte_ch();
  u8dec_cp_if   cp_ch();

  int decode_errors;
  int cp_pending;

  // Idle pattern, changed per phase by the stimulus process.
  logic sender_idle   = 1'b1;
  logic receiver_idle = 1'b1;
  logic hold_off      = 1'b0;   // one-shot request for a long receiver stall
  int   bytes_sent    = 0;
  int   quiet_cycles  = 0;

  always #5 clk = ~clk;

  utf8_codepoint_decoder_unit uut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .cp_out  (cp_ch)
  );

  utf8_codepoint_decoder_unit_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .byte_mon       (byte_ch),
    .cp_mon         (cp_ch),
    .mismatch_count (decode_errors),
    .cp_outstanding (cp_pending)
  );

  // Offer one byte and hold it until the transaction completes. Called right
  // after the previous transaction's rising edge, so the first falling edge
  // either drops valid for a gap or puts the next byte straight on the bus;
  // valid never gets two assignments in one step.
  task automatic send_byte(input logic [7:0] b, input logic fl);
    int gap;
    gap = sender_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.flush     <= fl;
    do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
    bytes_sent++;
  endtask

  // Build one sequence: mostly well formed with random content, some cut short
  // by a non-continuation byte, some plain noise. Flush lands anywhere.
  task automatic send_sequence();
    logic [7:0] seq [$];
    int         kind;
    int         len;
    int         cut;
    int         i;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 4);
    case (len)
      1: seq.push_back(8'($urandom_range(8'h00, 8'h7F)));
      2: seq.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      3: seq.push_back(8'($urandom_range(8'hE0, 8'hEF)));
      default: begin
        // favor F0-F4 so that valid four-byte values show up often
        if ($urandom_range(0, 3) == 0) seq.push_back(8'($urandom_range(8'hF0, 8'hF7)));
        else seq.push_back(8'($urandom_range(8'hF0, 8'hF4)));
      end
    endcase
    for (i = 1; i < len; i++) seq.push_back(8'h80 | 8'($urandom_range(0, 8'h3F)));
    if (kind >= 7 && kind <= 8 && len > 1) begin
      // cut after the lead or a few continuations, then break with a new start
      cut = $urandom_range(1, len - 1);
      while (seq.size() > cut) void'(seq.pop_back());
      if ($urandom_range(0, 1) == 0) seq.push_back(8'($urandom_range(8'h00, 8'h7F)));
      else seq.push_back(8'($urandom_range(8'hC0, 8'hFF)));
    end else if (kind == 9) begin
      seq.delete();
      repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[j]) send_byte(seq[j], $urandom_range(0, 15) == 0);
  endtask

  // Sender: reset, directed bytes, then random phases, then drain and verdict.
  initial begin
    int phase;
    int next_phase;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.flush     = 1'b0;
    phase      = 0;
    next_phase = N_DIRECTED;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int d = 0; d < N_DIRECTED; d++)
      send_byte(DIRECTED_BYTES[d][7:0], DIRECTED_BYTES[d][8]);

    while (bytes_sent < N_DIRECTED + BYTE_TARGET) begin
      if (bytes_sent >= next_phase) begin
        // Advance the idle pattern: first a stretch at full rate, then full
        // idling, then random choices; one phase forces a long receiver stall
        // while the sender streams without gaps.
        case (phase)
          0: begin
            sender_idle   = 1'b0;
            receiver_idle = 1'b0;
          end
          1: begin
            sender_idle   = 1'b1;
            receiver_idle = 1'b1;
          end
          HOLD_OFF_PHASE: begin
            sender_idle   = 1'b0;
            receiver_idle = 1'b0;
            hold_off      = 1'b1;
          end
          default: begin
            sender_idle   = 1'($urandom_range(0, 1));
            receiver_idle = 1'($urandom_range(0, 1));
          end
        endcase
        phase++;
        next_phase += PHASE_BYTES;
      end
      send_sequence();
    end
    @(negedge clk);
    byte_ch.valid <= 1'b0;

    // Drain: wait for every expected result, then let the pipeline settle so
    // that any extra result still shows up as a failure.
    while (cp_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decode_errors == 0 && cp_pending == 0) begin
      $display("[utf8_codepoint_decoder_unit] OK");
    end else begin
      $display("[utf8_codepoint_decoder_unit] ERROR");
    end
    $finish;
  end

  // Receiver: per result, draw a stall, then hold ready until a transaction.
  // A pending hold-off request drops ready for a long stretch instead, so the
  // block fills up and backs pressure onto its input.
  initial begin
    int stall;
    cp_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      stall = receiver_idle ? $urandom_range(0, 7) : 0;
      if (hold_off) begin
        hold_off = 1'b0;
        stall    = HOLD_OFF_CYCLES;
      end
      if (stall != 0) begin
        cp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      cp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(cp_ch.valid && cp_ch.ready));
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[utf8_codepoint_decoder_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
